// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the cache RTL.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while reset is released.
`define MTFC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define MTFC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/mtfc_pkg.sv -----
// Types and constants of the move-to-front key/value cache.
// Used by the cache cell and the top level; depends on nothing.
package mtfc_pkg;

    localparam int KEY_W  = 8;
    localparam int VAL_W  = 8;
    localparam int SIZE_W = 5;
    localparam int CNT_W  = 8;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    localparam logic REG_ACTIVE_SIZE = 1'b0;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_MOVE,
        CMD_INSERT,
        CMD_WRITE,
        CMD_CLEAR
    } t_cmd;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic             match;
        logic [VAL_W-1:0] value;
    } t_chain;

    typedef struct packed {
        t_cmd             cmd;
        logic [VAL_W-1:0] value;
    } t_cell_ctrl;

endpackage

// ----- hw/rtl/mtfc_cell.sv -----
// One cell of the cache chain: holds one entry, compares it with the key and
// takes its neighbor's entry on a shift. Depends on mtfc_pkg.
module mtfc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_first,
    input  logic                       i_in_range,
    input  logic [mtfc_pkg::KEY_W-1:0] i_key,
    input  mtfc_pkg::t_cell_ctrl       i_ctrl,
    input  mtfc_pkg::t_entry           i_prev,
    input  mtfc_pkg::t_chain           i_behind,
    output mtfc_pkg::t_entry           o_entry,
    output mtfc_pkg::t_chain           o_chain,
    output logic                       o_match
);

    logic                       r_valid;
    logic [mtfc_pkg::KEY_W-1:0] r_key;
    logic [mtfc_pkg::VAL_W-1:0] r_value;
    mtfc_pkg::t_entry           n_entry;
    logic                       w_match;

    assign w_match = r_valid && i_in_range && (r_key == i_key);
    assign o_match = w_match;
    assign o_entry = '{valid: r_valid, key: r_key, value: r_value};

    assign o_chain.match = w_match | i_behind.match;
    assign o_chain.value = i_behind.value | (w_match ? r_value : '0);

    always_comb begin
        n_entry = o_entry;
        unique case (i_ctrl.cmd)
            mtfc_pkg::CMD_NONE: begin
            end
            mtfc_pkg::CMD_CLEAR: begin
                n_entry.valid = 1'b0;
            end
            mtfc_pkg::CMD_MOVE: begin
                if (i_in_range) begin
                    if (i_first) begin
                        n_entry = '{valid: 1'b1, key: i_key, value: i_ctrl.value};
                    end else if (o_chain.match) begin
                        n_entry = i_prev;
                    end
                end
            end
            mtfc_pkg::CMD_INSERT: begin
                if (i_in_range) begin
                    if (i_first) begin
                        n_entry = '{valid: 1'b1, key: i_key, value: i_ctrl.value};
                    end else begin
                        n_entry = i_prev;
                    end
                end
            end
            mtfc_pkg::CMD_WRITE: begin
                if (w_match) begin
                    n_entry.value = i_ctrl.value;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_entry.key;
        r_value <= n_entry.value;
    end

endmodule

// ----- hw/rtl/move_to_front_key_value_cache_top.sv -----
// Top level of the move-to-front key/value cache: APB register, stream
// ports, output register and the chain of cells. Depends on mtfc_pkg,
// mtfc_cell and assert_macros.svh.
//
//   Channel   Direction  Handshake                    Word
//   s_axis    in         tvalid/tready                tdata key,value; tuser func
//   m_axis    out        tvalid/tready                tdata read_value; tuser hit
//   apb       in         psel/penable/pwrite, pready  active_size at address 0
//
// One word is taken per cycle while s_axis_tready is high: every cell compares its key in
// the cycle the word is accepted, and the cells shift on a lookup hit or an update miss.
// The result is registered and appears in the following cycle.
// The input stalls only while a result waits and m_axis_tready is low.
// Reset clears the valid marks at once; no clearing pass is needed.
module move_to_front_key_value_cache_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // key_id[7:0], write_value[15:8]
    input  logic        s_axis_tuser,  // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // read_value[7:0]
    output logic        m_axis_tuser   // hit[0]
);

    logic [mtfc_pkg::SIZE_W-1:0] r_active_size;
    logic                        r_out_valid;
    logic                        r_hit;
    logic [mtfc_pkg::VAL_W-1:0]  r_read_value;
    logic                        n_out_valid;

    logic                        w_cfg_write;
    logic                        w_accept;
    logic                        w_func;
    logic [mtfc_pkg::KEY_W-1:0]  w_key;
    logic [mtfc_pkg::VAL_W-1:0]  w_wval;
    logic                        w_hit;
    mtfc_pkg::t_cell_ctrl        w_ctrl;

    mtfc_pkg::t_entry            w_entry [MAX_ENTRIES];
    mtfc_pkg::t_entry            w_prev  [MAX_ENTRIES];
    mtfc_pkg::t_chain            w_chain [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0]      w_valid_vec;
    logic [MAX_ENTRIES-1:0]      w_match_vec;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready
                         && (paddr[2] == mtfc_pkg::REG_ACTIVE_SIZE);
    assign prdata      = (paddr[2] == mtfc_pkg::REG_ACTIVE_SIZE)
                         ? {{(32-mtfc_pkg::SIZE_W){1'b0}}, r_active_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_size <= '0;
        end else if (w_cfg_write) begin
            r_active_size <= pwdata[mtfc_pkg::SIZE_W-1:0];
        end
    end

    assign w_func        = s_axis_tuser;
    assign w_key         = s_axis_tdata[7:0];
    assign w_wval        = s_axis_tdata[15:8];
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_hit         = w_chain[0].match;

    always_comb begin
        w_ctrl.cmd   = mtfc_pkg::CMD_NONE;
        w_ctrl.value = w_wval;
        priority if (w_cfg_write) begin
            w_ctrl.cmd = mtfc_pkg::CMD_CLEAR;
        end else if (w_accept && w_func == mtfc_pkg::FUNC_LOOKUP) begin
            if (w_hit) begin
                w_ctrl.cmd   = mtfc_pkg::CMD_MOVE;
                w_ctrl.value = w_chain[0].value;
            end
        end else if (w_accept) begin
            w_ctrl.cmd = w_hit ? mtfc_pkg::CMD_WRITE : mtfc_pkg::CMD_INSERT;
        end else begin
            w_ctrl.cmd = mtfc_pkg::CMD_NONE;
        end
    end

    assign w_chain[MAX_ENTRIES] = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g] = '0;
        end else begin : g_body
            assign w_prev[g] = w_entry[g-1];
        end

        mtfc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_first    (g == 0),
            .i_in_range (mtfc_pkg::CNT_W'(g) <
                         {{(mtfc_pkg::CNT_W-mtfc_pkg::SIZE_W){1'b0}}, r_active_size}),
            .i_key      (w_key),
            .i_ctrl     (w_ctrl),
            .i_prev     (w_prev[g]),
            .i_behind   (w_chain[g+1]),
            .o_entry    (w_entry[g]),
            .o_chain    (w_chain[g]),
            .o_match    (w_match_vec[g])
        );

        assign w_valid_vec[g] = w_entry[g].valid;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit        <= w_hit;
            r_read_value <= (w_func == mtfc_pkg::FUNC_LOOKUP && w_hit)
                            ? w_chain[0].value : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_read_value;
    assign m_axis_tuser  = r_hit;

`include "assert_macros.svh"

    `MTFC_ASSERT(a_miss_reads_zero, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'd0))
    `MTFC_ASSERT(a_valid_prefix, (w_valid_vec & (w_valid_vec + 1'b1)) == '0)
    `MTFC_ASSERT(a_single_match, $onehot0(w_match_vec))
    `MTFC_ASSERT(a_clear_on_config, w_cfg_write |=> (w_valid_vec == '0))
    `MTFC_ASSERT_ALWAYS(a_ready_when_empty, !r_out_valid |-> s_axis_tready)

endmodule

// ----- dv/move_to_front_key_value_cache_top_tb.sv -----
// Self-checking testbench of move_to_front_key_value_cache_top: stream words are
// checked against a recency-ordered cache predictor kept in a scoreboard class.
// Depends on mtfc_pkg and the cache RTL; reads no files.
module move_to_front_key_value_cache_top_tb;

    localparam int MAX_ENTRIES = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD = 150;
    localparam int ITEMS_PER_SEGMENT = 120;
    localparam int NUM_SEGMENTS = 10;
    localparam logic [2:0] ADDR_ACTIVE_SIZE = {mtfc_pkg::REG_ACTIVE_SIZE, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    typedef struct packed {
        logic                       hit;
        logic [mtfc_pkg::VAL_W-1:0] value;
    } t_mtf_result;

    class mtf_cache_scoreboard;
        logic [mtfc_pkg::KEY_W-1:0] keys[MAX_ENTRIES];
        logic [mtfc_pkg::VAL_W-1:0] values[MAX_ENTRIES];
        bit                         valid[MAX_ENTRIES];
        int unsigned                active_size;
        t_mtf_result                expected_q[$];
        int                         mismatches;

        function new();
            active_size = 0;
            mismatches = 0;
            clear_entries();
        endfunction

        function void clear_entries();
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                keys[i] = '0;
                values[i] = '0;
                valid[i] = 1'b0;
            end
        endfunction

        function void set_size(logic [mtfc_pkg::SIZE_W-1:0] size);
            active_size = size;
            clear_entries();
        endfunction

        function void report(string what, int exp_val, int act_val);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH %s: expected %0d, got %0d", what, exp_val, act_val);
        endfunction

        function void shift_back(int unsigned pos);
            for (int unsigned i = pos; i > 0; i--) begin
                keys[i] = keys[i-1];
                values[i] = values[i-1];
                valid[i] = valid[i-1];
            end
        endfunction

        function void note_word(logic func, logic [mtfc_pkg::KEY_W-1:0] key,
                                logic [mtfc_pkg::VAL_W-1:0] wval);
            int unsigned used;
            int unsigned pos;
            logic [mtfc_pkg::VAL_W-1:0] found;
            t_mtf_result res;
            used = (active_size > MAX_ENTRIES) ? MAX_ENTRIES : active_size;
            res = '0;
            if (used > 0) begin
                pos = 0;
                while (pos < used && valid[pos] && keys[pos] != key)
                    pos++;
                if (pos < used && !valid[pos])
                    pos = used;
                if (func == mtfc_pkg::FUNC_LOOKUP) begin
                    if (pos < used) begin
                        found = values[pos];
                        res.hit = 1'b1;
                        res.value = found;
                        shift_back(pos);
                        keys[0] = key;
                        values[0] = found;
                        valid[0] = 1'b1;
                    end
                end else if (pos < used) begin
                    res.hit = 1'b1;
                    values[pos] = wval;
                end else begin
                    shift_back(used - 1);
                    keys[0] = key;
                    values[0] = wval;
                    valid[0] = 1'b1;
                end
            end
            expected_q.push_back(res);
        endfunction

        function void check_word(logic hit, logic [mtfc_pkg::VAL_W-1:0] rval);
            t_mtf_result exp_res;
            if (expected_q.size() == 0) begin
                report("word with nothing expected, hit", -1, hit);
            end else begin
                exp_res = expected_q.pop_front();
                if (hit !== exp_res.hit)
                    report("hit", exp_res.hit, hit);
                if (rval !== exp_res.value)
                    report("read_value", exp_res.value, rval);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;  // key_id[7:0], write_value[15:8]
    logic        s_axis_tuser = 1'b0;  // func[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;  // read_value[7:0]
    logic        m_axis_tuser;  // hit[0]

    mtf_cache_scoreboard sb = new();

    int          idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_req = 1'b0;
    int          hold_cnt = 0;
    bit          hold_armed = 1'b0;
    int          quiet_cycles = 0;
    logic [mtfc_pkg::KEY_W-1:0] key_pool[20];

    move_to_front_key_value_cache_top #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // The receiver stalls at random, or for a long stretch once hold_req rises.
    always @(posedge i_clk) begin
        if (hold_req && !hold_armed) begin
            hold_cnt = LONG_HOLD;
            hold_armed = 1'b1;
        end
        if (!hold_req)
            hold_armed = 1'b0;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_word(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("move_to_front_key_value_cache_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(logic func, logic [mtfc_pkg::KEY_W-1:0] key,
                             logic [mtfc_pkg::VAL_W-1:0] wval);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {wval, key};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0)
            @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_ACTIVE_SIZE)
            sb.set_size(data[mtfc_pkg::SIZE_W-1:0]);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_check_size();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_ACTIVE_SIZE;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[mtfc_pkg::SIZE_W-1:0] !== sb.active_size[mtfc_pkg::SIZE_W-1:0])
            sb.report("active_size readback", sb.active_size,
                      prdata[mtfc_pkg::SIZE_W-1:0]);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_size(logic [mtfc_pkg::SIZE_W-1:0] size);
        drain();
        apb_write(ADDR_ACTIVE_SIZE,
                  {(32-mtfc_pkg::SIZE_W)'($urandom_range(32'h07ff_ffff)), size});
        apb_check_size();
    endtask

    task automatic send_random_word(int unsigned size);
        logic [mtfc_pkg::KEY_W-1:0] key;
        int unsigned pool_n;
        pool_n = ((size > MAX_ENTRIES) ? MAX_ENTRIES : size) + 4;
        if ($urandom_range(99) < 80)
            key = key_pool[$urandom_range(pool_n - 1)];
        else
            key = mtfc_pkg::KEY_W'($urandom_range(255));
        send_word($urandom_range(1) ? mtfc_pkg::FUNC_UPDATE : mtfc_pkg::FUNC_LOOKUP, key,
                  mtfc_pkg::VAL_W'($urandom_range(255)));
    endtask

    initial begin
        int unsigned seg_size;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The cache is disabled straight after reset.
        send_word(mtfc_pkg::FUNC_UPDATE, 8'h5A, 8'hC3);
        send_word(mtfc_pkg::FUNC_LOOKUP, 8'h5A, 8'h00);

        set_size(5'd4);
        send_word(mtfc_pkg::FUNC_LOOKUP, 8'h00, 8'hFF);
        send_word(mtfc_pkg::FUNC_UPDATE, 8'h00, 8'hFF);
        send_word(mtfc_pkg::FUNC_UPDATE, 8'hFF, 8'h00);
        send_word(mtfc_pkg::FUNC_LOOKUP, 8'h00, 8'h00);
        send_word(mtfc_pkg::FUNC_UPDATE, 8'hFF, 8'hA5);
        send_word(mtfc_pkg::FUNC_LOOKUP, 8'hFF, 8'h00);
        send_word(mtfc_pkg::FUNC_UPDATE, 8'h12, 8'h34);
        send_word(mtfc_pkg::FUNC_UPDATE, 8'h56, 8'h78);
        send_word(mtfc_pkg::FUNC_UPDATE, 8'h9A, 8'hBC);
        send_word(mtfc_pkg::FUNC_LOOKUP, 8'h00, 8'h00);
        send_word(mtfc_pkg::FUNC_LOOKUP, 8'hFF, 8'h00);
        drain();
        // A write to an unmapped address must leave the cache contents alone.
        apb_write(ADDR_UNMAPPED, 32'h0000_0000);
        apb_check_size();
        send_word(mtfc_pkg::FUNC_LOOKUP, 8'h12, 8'h00);

        set_size(5'd1);
        send_word(mtfc_pkg::FUNC_UPDATE, 8'h80, 8'h01);
        send_word(mtfc_pkg::FUNC_LOOKUP, 8'h80, 8'h00);
        send_word(mtfc_pkg::FUNC_UPDATE, 8'h7F, 8'h02);
        send_word(mtfc_pkg::FUNC_LOOKUP, 8'h80, 8'h00);
        send_word(mtfc_pkg::FUNC_LOOKUP, 8'h7F, 8'h00);

        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            case (seg)
                0: seg_size = 16;
                1: seg_size = 1;
                2: seg_size = 31;
                3: seg_size = 0;
                4: seg_size = 17;
                5: seg_size = 3;
                6: seg_size = $urandom_range(31);
                7: seg_size = 16;
                8: seg_size = 2;
                default: seg_size = 8;
            endcase
            case (seg % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 62; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 62; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            foreach (key_pool[i])
                key_pool[i] = mtfc_pkg::KEY_W'($urandom_range(255));
            set_size(seg_size[mtfc_pkg::SIZE_W-1:0]);
            for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
                if (seg == 4 && n == 30)
                    hold_req <= 1'b1;
                if (seg == 4 && n == 60)
                    hold_req <= 1'b0;
                if (seg == 5 && n == 60)
                    drain();
                send_random_word(seg_size);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("move_to_front_key_value_cache_top regression: pass");
        end else begin
            $display("move_to_front_key_value_cache_top regression: fail");
        end
        $finish;
    end

endmodule
